[hw/rtl/bpe_pkg.sv]
// Shared types and constants for the button press event generator.
package bpe_pkg;

  localparam int NumBtn   = 3;
  localparam int MaxEv    = 8;
  localparam int BtnMaxEv = 4;
  localparam int EvIdxW   = 3;
  localparam int EvCntW   = 4;
  localparam int BtnCntW  = 3;
  localparam int CfgW     = 16;
  localparam int CfgIdxW  = 2;
  localparam int SeqW     = 32;
  localparam int NowW     = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLongHold    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRepeatPeriod = 2'd1;

  localparam logic [CfgW-1:0] LongHoldRst     = 16'd500;
  localparam logic [CfgW-1:0] RepeatPeriodRst = 16'd200;

  // logical key codes
  localparam logic [1:0] KeyUp   = 2'd0;
  localparam logic [1:0] KeyDown = 2'd1;
  localparam logic [1:0] KeyOk   = 2'd2;
  localparam logic [1:0] KeyBack = 2'd3;

  // event kinds
  localparam logic [2:0] EvPress   = 3'd0;
  localparam logic [2:0] EvRelease = 3'd1;
  localparam logic [2:0] EvShort   = 3'd2;
  localparam logic [2:0] EvLong    = 3'd3;
  localparam logic [2:0] EvRepeat  = 3'd4;

  // key per button: A, B, power
  localparam logic [1:0] BaseKey [NumBtn] = '{KeyOk, KeyDown, KeyBack};
  localparam logic [1:0] HeldKey [NumBtn] = '{KeyOk, KeyUp, KeyBack};

  typedef struct packed {
    logic [1:0] key;
    logic [2:0] kind;
  } ev_t;

  // all events of one poll, packed from slot 0
  typedef struct packed {
    ev_t [MaxEv-1:0]   evs;
    logic [EvCntW-1:0] cnt;
  } poll_t;

endpackage

[hw/rtl/bpe_front.sv]
// Front end: tracks button state, classifies each poll into an event list.
module bpe_front #(
  parameter int TIME_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bpe_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bpe_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        accept_i,
  input  logic [bpe_pkg::NumBtn-1:0]  level_i,
  input  logic [bpe_pkg::NowW-1:0]    now_ms_i,
  output logic                        rec_valid_o,
  output bpe_pkg::poll_t              rec_o
);
  import bpe_pkg::*;

  localparam int CmpW = TIME_BITS + CfgW;

  logic [CfgW-1:0]      long_hold_q, repeat_q;
  logic [TIME_BITS-1:0] ct_q [NumBtn];
  logic [TIME_BITS-1:0] ct_d [NumBtn];
  logic [NumBtn-1:0]    pr_q, pr_d, ld_q, ld_d;
  logic [TIME_BITS-1:0] tick;
  logic [TIME_BITS+NowW-1:0] tick_x;

  ev_t [BtnMaxEv-1:0]   bev [NumBtn];
  logic [BtnCntW-1:0]   bn  [NumBtn];
  logic [EvCntW-1:0]    off [NumBtn];
  logic [EvCntW-1:0]    total;

  // time base at the configured width
  assign tick_x = {{TIME_BITS{1'b0}}, now_ms_i};
  assign tick   = tick_x[TIME_BITS-1:0];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_hold_q <= LongHoldRst;
      repeat_q    <= RepeatPeriodRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgLongHold)     long_hold_q <= cfg_data_i;
      if (cfg_idx_i == CfgRepeatPeriod) repeat_q    <= cfg_data_i;
    end
  end

  // per-button classification, buttons are independent
  always_comb begin
    logic [TIME_BITS-1:0] diff;
    logic [CmpW-1:0]      diff_x;
    logic                 now_p;
    logic                 long_hit, rep_hit;
    for (int b = 0; b < NumBtn; b++) begin
      diff     = tick - ct_q[b];
      diff_x   = {{CfgW{1'b0}}, diff};
      now_p    = ~level_i[b];
      long_hit = !ld_q[b] && (diff_x > {{TIME_BITS{1'b0}}, long_hold_q});
      rep_hit  = ld_q[b]  && (diff_x > {{TIME_BITS{1'b0}}, repeat_q});
      ct_d[b]  = ct_q[b];
      pr_d[b]  = pr_q[b];
      ld_d[b]  = ld_q[b];
      bev[b]   = '0;
      bn[b]    = '0;
      if (now_p != pr_q[b]) begin
        pr_d[b] = now_p;
        if (now_p) begin
          ct_d[b]   = tick;
          ld_d[b]   = 1'b0;
          bev[b][0] = '{key: BaseKey[b], kind: EvPress};
          bn[b]     = 3'd1;
        end else if (!ld_q[b]) begin
          bev[b][0] = '{key: BaseKey[b], kind: EvShort};
          bev[b][1] = '{key: BaseKey[b], kind: EvRelease};
          bn[b]     = 3'd2;
        end else begin
          bev[b][0] = '{key: HeldKey[b], kind: EvRelease};
          bn[b]     = 3'd1;
        end
      end else if (now_p) begin
        if (long_hit) begin
          ld_d[b] = 1'b1;
          ct_d[b] = tick;
          if (HeldKey[b] != BaseKey[b]) begin
            // remap from the base key to the held key first
            bev[b][0] = '{key: BaseKey[b], kind: EvRelease};
            bev[b][1] = '{key: HeldKey[b], kind: EvPress};
            bev[b][2] = '{key: HeldKey[b], kind: EvShort};
            bev[b][3] = '{key: HeldKey[b], kind: EvLong};
            bn[b]     = 3'd4;
          end else begin
            bev[b][0] = '{key: HeldKey[b], kind: EvLong};
            bn[b]     = 3'd1;
          end
        end else if (rep_hit) begin
          ct_d[b]   = tick;
          bev[b][0] = '{key: HeldKey[b], kind: EvRepeat};
          bn[b]     = 3'd1;
        end
      end
    end
  end

  // pack button lists into one record in button order
  always_comb begin
    logic [EvCntW-1:0] slot;
    off[0] = '0;
    for (int b = 1; b < NumBtn; b++) begin
      off[b] = off[b-1] + EvCntW'(bn[b-1]);
    end
    total = off[NumBtn-1] + EvCntW'(bn[NumBtn-1]);
    rec_o = '0;
    for (int b = 0; b < NumBtn; b++) begin
      for (int i = 0; i < BtnMaxEv; i++) begin
        slot = off[b] + EvCntW'(i);
        if (BtnCntW'(i) < bn[b]) begin
          rec_o.evs[slot[EvIdxW-1:0]] = bev[b][i];
        end
      end
    end
    rec_o.cnt   = total;
    rec_valid_o = accept_i && (total != '0);
  end

  // button state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_q <= '0;
      ld_q <= '0;
      for (int b = 0; b < NumBtn; b++) ct_q[b] <= '0;
    end else if (accept_i) begin
      pr_q <= pr_d;
      ld_q <= ld_d;
      for (int b = 0; b < NumBtn; b++) ct_q[b] <= ct_d[b];
    end
  end

endmodule

[hw/rtl/bpe_queue.sv]
// Short queue of poll records between front and back.
module bpe_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bpe_pkg::poll_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bpe_pkg::poll_t data_o
);
  import bpe_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  poll_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[hw/rtl/bpe_back.sv]
// Back end: drains one event per cycle into the result register while the result register is empty or being popped.
module bpe_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rec_valid_i,
  input  bpe_pkg::poll_t           rec_i,
  output logic                     rec_pop_o,
  output logic                     empty_o,
  input  logic                     pop_i,
  output logic [1:0]               key_code_o,
  output logic [2:0]               event_kind_o,
  output logic [bpe_pkg::SeqW-1:0] sequence_number_o,
  output logic                     last_of_poll_o
);
  import bpe_pkg::*;

  logic [EvIdxW-1:0] idx_q;
  logic [SeqW-1:0]   seq_q;
  logic              out_valid_q;
  logic              load, last;
  ev_t               ev_q;
  logic [SeqW-1:0]   out_seq_q;
  logic              out_last_q;

  assign load      = rec_valid_i && (!out_valid_q || pop_i);
  assign last      = ({1'b0, idx_q} + 1'b1) == rec_i.cnt;
  assign rec_pop_o = load && last;
  assign empty_o   = !out_valid_q;

  assign key_code_o        = ev_q.key;
  assign event_kind_o      = ev_q.kind;
  assign sequence_number_o = out_seq_q;
  assign last_of_poll_o    = out_last_q;

  // control: slot index, event counter, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= last ? '0 : idx_q + 1'b1;
        seq_q       <= seq_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      ev_q       <= rec_i.evs[idx_q];
      out_seq_q  <= seq_q;
      out_last_q <= last;
    end
  end

endmodule

[hw/rtl/button_press_event_generator.sv]
// Path: an accepted poll is written into the queue, then its events are loaded
// in turn into the result register. Throughput: one poll per cycle is taken
// while the queue has room; events leave one per cycle while pop is held and
// events are queued. A poll that causes no event occupies no queue slot.
// Reset: buttons released, flags and times zero, event count zero,
// hold time 500 ms, repeat period 200 ms, queue and result register empty.
module button_press_event_generator #(
  parameter int TIME_BITS   = 32,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bpe_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bpe_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        push,
  output logic                        full,
  input  logic                        level_a_i,
  input  logic                        level_b_i,
  input  logic                        level_power_i,
  input  logic [bpe_pkg::NowW-1:0]    now_ms_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [1:0]                  key_code_o,
  output logic [2:0]                  event_kind_o,
  output logic [bpe_pkg::SeqW-1:0]    sequence_number_o,
  output logic                        last_of_poll_o
);
  import bpe_pkg::*;

  logic  accept, rec_valid, rec_pop, q_valid;
  poll_t rec, q_head;

  assign accept = push && !full;

  // classify polls
  bpe_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .level_i     ({level_power_i, level_b_i, level_a_i}),
    .now_ms_i    (now_ms_i),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  // decouple front and back
  bpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_valid),
    .data_i  (rec),
    .full_o  (full),
    .pop_i   (rec_pop),
    .valid_o (q_valid),
    .data_o  (q_head)
  );

  // drain events
  bpe_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rec_valid_i       (q_valid),
    .rec_i             (q_head),
    .rec_pop_o         (rec_pop),
    .empty_o           (empty),
    .pop_i             (pop),
    .key_code_o        (key_code_o),
    .event_kind_o      (event_kind_o),
    .sequence_number_o (sequence_number_o),
    .last_of_poll_o    (last_of_poll_o)
  );

endmodule
